// ----- hdl/ddo_pkg.sv -----
// Package for the differential-drive odometry block: constants, item types, states and the arctangent table.
package ddo_pkg;

	// Number of CORDIC rotations per item; the arctangent table holds thirty entries.
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 30;
	localparam int STEP_W = 5;

	// CORDIC datapath width, Q2.30 with headroom.
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 2'd1;
	localparam logic [CFG_W-1:0] DISTANCE_SCALE_RST = 24'd5033;
	localparam logic [CFG_W-1:0] TURN_GAIN_RST = 24'd14834176;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic signed [15:0] right_speed;
		logic signed [15:0] left_speed;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
	} out_item_t;

	// Cosine and sine returned by the CORDIC unit, Q2.30.
	typedef struct packed {
		logic signed [CW-1:0] cos_v;
		logic signed [CW-1:0] sin_v;
	} cordic_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_R,
		ST_MUL_L,
		ST_SUMDIFF,
		ST_TURN_LO,
		ST_TURN_HI,
		ST_MID,
		ST_CORDIC,
		ST_SIGN,
		ST_X_LO,
		ST_X_HI,
		ST_X_ADD,
		ST_Y_LO,
		ST_Y_HI,
		ST_Y_ADD,
		ST_OUT
	} state_t;

	// Arctangent of 2^-i as a binary angle, full turn equals 2^32.
	function automatic logic signed [CW-1:0] atan_at(input logic [STEP_W-1:0] idx);
		logic signed [CW-1:0] v;
		unique case (idx)
			5'd0:  v = 34'sh20000000;
			5'd1:  v = 34'sh12E4051D;
			5'd2:  v = 34'sh09FB385B;
			5'd3:  v = 34'sh051111D4;
			5'd4:  v = 34'sh028B0D43;
			5'd5:  v = 34'sh0145D7E1;
			5'd6:  v = 34'sh00A2F61E;
			5'd7:  v = 34'sh00517C55;
			5'd8:  v = 34'sh0028BE53;
			5'd9:  v = 34'sh00145F2E;
			5'd10: v = 34'sh000A2F98;
			5'd11: v = 34'sh000517CC;
			5'd12: v = 34'sh00028BE6;
			5'd13: v = 34'sh000145F3;
			5'd14: v = 34'sh0000A2F9;
			5'd15: v = 34'sh0000517C;
			5'd16: v = 34'sh000028BE;
			5'd17: v = 34'sh0000145F;
			5'd18: v = 34'sh00000A2F;
			5'd19: v = 34'sh00000517;
			5'd20: v = 34'sh0000028B;
			5'd21: v = 34'sh00000145;
			5'd22: v = 34'sh000000A2;
			5'd23: v = 34'sh00000051;
			5'd24: v = 34'sh00000028;
			5'd25: v = 34'sh00000014;
			5'd26: v = 34'sh0000000A;
			5'd27: v = 34'sh00000005;
			5'd28: v = 34'sh00000002;
			5'd29: v = 34'sh00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/ddo_mul.sv -----
// Shared signed multiplier with a registered product.
module ddo_mul
	import ddo_pkg::*;
(
	input  logic                       clk,
	input  logic signed [MUL_A_W-1:0]  op_a,
	input  logic signed [MUL_B_W-1:0]  op_b,
	output logic signed [MUL_P_W-1:0]  prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	// One product per cycle, taken by the sequencer in the following state.
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// ----- hdl/ddo_cordic.sv -----
// Iterative CORDIC unit: cosine and sine of a binary angle, one rotation per cycle.
module ddo_cordic
	import ddo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] angle,
	output logic        done,
	output cordic_res_t res
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic signed [CW-1:0]  x_q;
	logic signed [CW-1:0]  y_q;
	logic signed [CW-1:0]  a_q;
	logic                  flip_q;
	cordic_res_t           res_q;

	logic signed [CW-1:0]  ang_s;
	logic signed [CW-1:0]  ang_fold;
	logic                  flip_d;
	logic signed [CW-1:0]  sx;
	logic signed [CW-1:0]  sy;
	logic signed [CW-1:0]  x_nx;
	logic signed [CW-1:0]  y_nx;
	logic                  last;

	// Fold angles beyond a quarter turn by a half turn; results are negated later.
	always_comb begin
		ang_s = CW'($signed(angle));
		ang_fold = ang_s;
		flip_d = 1'b0;
		if (ang_s > 34'sd1073741824) begin
			ang_fold = ang_s - 34'sd2147483648;
			flip_d = 1'b1;
		end else if (ang_s < -34'sd1073741824) begin
			ang_fold = ang_s + 34'sd2147483648;
			flip_d = 1'b1;
		end
	end

	// One rotation: shifted copies of both components and the add or subtract.
	always_comb begin
		sx = x_q >>> step_q;
		sy = y_q >>> step_q;
		if (a_q >= 0) begin
			x_nx = x_q - sy;
			y_nx = y_q + sx;
		end else begin
			x_nx = x_q + sy;
			y_nx = y_q - sx;
		end
		last = (step_q == STEP_W'(CORDIC_STEPS - 1));
	end

	// Control: step counter, busy and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: vector, residual angle and the final results.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_START;
			y_q <= '0;
			a_q <= ang_fold;
			flip_q <= flip_d;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			if (a_q >= 0) begin
				a_q <= a_q - atan_at(step_q);
			end else begin
				a_q <= a_q + atan_at(step_q);
			end
			if (last) begin
				res_q.cos_v <= flip_q ? -x_nx : x_nx;
				res_q.sin_v <= flip_q ? -y_nx : y_nx;
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ----- hdl/diff_drive_odometry.sv -----
// Top level of the differential-drive odometry block: sequencer, pose state and output register.
//
// Usage: each input item is one sampling tick carrying the right and left wheel speeds.
// The block scales both to distances, advances the heading by half the turn, takes cosine
// and sine there with CORDIC, adds the rounded x and y steps to the saturating position,
// and emits the new pose as one result item.
// Input channel: in_valid, in_stall, in_data. in_stall is high while an item is at work.
// Output channel: out_valid, out_stall, out_data, held in an output register.
// Items are worked one at a time; the pace is set by the one-rotation-per-cycle CORDIC
// loop and the shared multiplier, which takes eight products per item.
// The next item is accepted while a result still waits in the output register; if the
// receiver stalls past the end of the following item, the block holds in its last state.
// Configuration: cfg_wen, cfg_index, cfg_data, to be written only while the block is idle,
// which the block itself does not enforce; unknown indexes are ignored.
// Reset: the pose clears to zero, the registers take their defaults, no result is pending.
module diff_drive_odometry
	import ddo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]          dist_scale_q;
	logic [CFG_W-1:0]          turn_gain_q;

	logic signed [31:0]        x_q;
	logic signed [31:0]        y_q;
	logic [31:0]               heading_q;

	in_item_t                  in_q;
	logic signed [39:0]        dr_q;
	logic signed [40:0]        sum_q;
	logic signed [40:0]        diff_q;
	logic [47:0]               plo_q;
	logic [31:0]               dth_q;
	logic [31:0]               mcx_q;
	logic [31:0]               mcy_q;
	logic                      negx_q;
	logic                      negy_q;
	logic [40:0]               ms_q;
	logic [56:0]               low_q;

	logic                      out_valid_q;
	out_item_t                 out_q;

	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [MUL_P_W-1:0] prod;

	logic                      cor_start;
	logic [31:0]               mid_angle;
	logic                      cor_done;
	cordic_res_t               cor_res;

	logic                      in_acc;
	logic                      out_free;
	logic [32:0]               turn_sum;
	logic [49:0]               q_sum;
	logic [26:0]               q_mag;
	logic signed [32:0]        delta;
	logic signed [32:0]        pos_old;
	logic signed [32:0]        pos_sum;
	logic signed [31:0]        pos_sat;
	logic signed [CW-1:0]      cos_abs;
	logic signed [CW-1:0]      sin_abs;
	logic signed [40:0]        sum_abs;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	ddo_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	ddo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (mid_angle),
		.done   (cor_done),
		.res    (cor_res)
	);

	// Next state and the start pulse for the CORDIC unit.
	always_comb begin
		state_d = state_q;
		cor_start = 1'b0;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_MUL_R;
			ST_MUL_R:   state_d = ST_MUL_L;
			ST_MUL_L:   state_d = ST_SUMDIFF;
			ST_SUMDIFF: state_d = ST_TURN_LO;
			ST_TURN_LO: state_d = ST_TURN_HI;
			ST_TURN_HI: state_d = ST_MID;
			ST_MID: begin
				cor_start = 1'b1;
				state_d = ST_CORDIC;
			end
			ST_CORDIC:  if (cor_done) state_d = ST_SIGN;
			ST_SIGN:    state_d = ST_X_LO;
			ST_X_LO:    state_d = ST_X_HI;
			ST_X_HI:    state_d = ST_X_ADD;
			ST_X_ADD:   state_d = ST_Y_LO;
			ST_Y_LO:    state_d = ST_Y_HI;
			ST_Y_HI:    state_d = ST_Y_ADD;
			ST_Y_ADD:   state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_MUL_R: begin
				op_a = MUL_A_W'(in_q.right_speed);
				op_b = {1'b0, dist_scale_q};
			end
			ST_MUL_L: begin
				op_a = MUL_A_W'(in_q.left_speed);
				op_b = {1'b0, dist_scale_q};
			end
			ST_TURN_LO: begin
				op_a = {9'b0, diff_q[23:0]};
				op_b = {1'b0, turn_gain_q};
			end
			ST_TURN_HI: begin
				op_a = MUL_A_W'($signed(diff_q[40:24]));
				op_b = {1'b0, turn_gain_q};
			end
			ST_X_LO, ST_X_HI: begin
				op_a = {1'b0, mcx_q};
				op_b = (state_q == ST_X_LO) ? {1'b0, ms_q[23:0]} : {8'b0, ms_q[40:24]};
			end
			ST_Y_LO, ST_Y_HI: begin
				op_a = {1'b0, mcy_q};
				op_b = (state_q == ST_Y_LO) ? {1'b0, ms_q[23:0]} : {8'b0, ms_q[40:24]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Turn and mid heading: bits 56 to 24 of the difference times the gain.
	assign turn_sum  = prod[32:0] + {9'b0, plo_q[47:24]};
	assign mid_angle = heading_q + turn_sum[32:1];

	// Magnitudes and signs for the position step.
	assign cos_abs = cor_res.cos_v[CW-1] ? -cor_res.cos_v : cor_res.cos_v;
	assign sin_abs = cor_res.sin_v[CW-1] ? -cor_res.sin_v : cor_res.sin_v;
	assign sum_abs = sum_q[40] ? -sum_q : sum_q;

	// Rounded step, ties away from zero, then the saturating add to x or y.
	always_comb begin
		q_sum = prod[49:0] + {17'b0, low_q[56:24]};
		q_mag = q_sum[49:23];
		if (state_q == ST_X_ADD) begin
			delta = negx_q ? -$signed({6'b0, q_mag}) : $signed({6'b0, q_mag});
			pos_old = {x_q[31], x_q};
		end else begin
			delta = negy_q ? -$signed({6'b0, q_mag}) : $signed({6'b0, q_mag});
			pos_old = {y_q[31], y_q};
		end
		pos_sum = pos_old + delta;
		if (pos_sum[32] != pos_sum[31]) begin
			pos_sat = pos_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
		unique case (state_q)
			ST_MUL_L:   dr_q <= prod[39:0];
			ST_SUMDIFF: begin
				sum_q  <= {dr_q[39], dr_q} + {prod[39], prod[39:0]};
				diff_q <= {dr_q[39], dr_q} - {prod[39], prod[39:0]};
			end
			ST_TURN_HI: plo_q <= prod[47:0];
			ST_MID:     dth_q <= turn_sum[31:0];
			ST_SIGN: begin
				mcx_q  <= cos_abs[31:0];
				mcy_q  <= sin_abs[31:0];
				negx_q <= sum_q[40] ^ cor_res.cos_v[CW-1];
				negy_q <= sum_q[40] ^ cor_res.sin_v[CW-1];
				ms_q   <= sum_abs;
			end
			ST_X_HI, ST_Y_HI: low_q <= prod[56:0] + (57'd1 << 46);
			default: begin
			end
		endcase
	end

	// Configuration registers, pose state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_scale_q <= DISTANCE_SCALE_RST;
			turn_gain_q  <= TURN_GAIN_RST;
			x_q          <= '0;
			y_q          <= '0;
			heading_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == REG_DISTANCE_SCALE) begin
					dist_scale_q <= cfg_data;
				end else if (cfg_index == REG_TURN_GAIN) begin
					turn_gain_q <= cfg_data;
				end
			end
			if (state_q == ST_X_ADD) begin
				x_q <= pos_sat;
			end
			if (state_q == ST_Y_ADD) begin
				y_q <= pos_sat;
			end
			if (state_q == ST_OUT && out_free) begin
				heading_q   <= heading_q + dth_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded together with out_valid.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.pos_x   <= x_q;
			out_q.pos_y   <= y_q;
			out_q.heading <= $signed(heading_q + dth_q);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The CORDIC unit reports completion only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_CORDIC)
		else $error("CORDIC done outside its wait state");

	// An accepted item always starts the multiply sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_MUL_R)
		else $error("accepted item did not start the sequence");

	// The heading moves only when a result is written out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(heading_q != $past(heading_q)) |-> $past(state_q) == ST_OUT)
		else $error("heading changed outside the output step");

	// A new result appears only from the output step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

endmodule

// ----- verif/tb_diff_drive_odometry.sv -----
// Self-checking testbench for the differential-drive odometry block, with its own pose predictor.

// Keeps a predicted pose and configuration, and checks every pose that the block emits.
class odometry_scoreboard;
	logic [ddo_pkg::CFG_W-1:0] dist_scale;
	logic [ddo_pkg::CFG_W-1:0] turn_gain;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic [31:0] heading;
	longint atan_tab [30];
	ddo_pkg::out_item_t expected_poses [$];
	int unsigned n_ticks, n_checked, n_errors, n_writes, n_clipped, n_wraps, n_flips;

	function new();
		// Arctangent of 2^-i as a binary angle.
		atan_tab = '{'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
			'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
			'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
			'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
			'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
			'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
		dist_scale = ddo_pkg::DISTANCE_SCALE_RST;
		turn_gain = ddo_pkg::TURN_GAIN_RST;
		x_pos = '0;
		y_pos = '0;
		heading = '0;
	endfunction

	// A register write; indexes without a register are ignored.
	function void set_reg(logic [ddo_pkg::CFG_IDX_W-1:0] idx, logic [ddo_pkg::CFG_W-1:0] data);
		n_writes++;
		case (idx)
			ddo_pkg::REG_DISTANCE_SCALE: dist_scale = data;
			ddo_pkg::REG_TURN_GAIN: turn_gain = data;
			default: ;
		endcase
	endfunction

	function int unsigned pending();
		return expected_poses.size();
	endfunction

	// Cosine and sine of a binary angle in Q2.30, folding angles past a quarter turn.
	function void sincos_of(input logic [31:0] ang, output longint cosv, output longint sinv,
			output bit flip);
		longint a, cx, cy, sx, sy, t;
		int i;
		a = longint'($signed(ang));
		flip = 1'b0;
		if (a > 64'sd1073741824) begin
			a -= 64'sd2147483648;
			flip = 1'b1;
		end else if (a < -64'sd1073741824) begin
			a += 64'sd2147483648;
			flip = 1'b1;
		end
		cx = 64'sd652032874;
		cy = 0;
		for (i = 0; i < ddo_pkg::CORDIC_STEPS && i < 30; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (a >= 0) begin
				t = cx - sy;
				cy = cy + sx;
				a -= atan_tab[i];
			end else begin
				t = cx + sy;
				cy = cy - sx;
				a += atan_tab[i];
			end
			cx = t;
		end
		cosv = flip ? -cx : cx;
		sinv = flip ? -cy : cy;
	endfunction

	// Distance times cosine or sine down to Q16.16, rounding the magnitude half away from zero.
	function longint step_of(longint s, longint c);
		logic [127:0] m;
		logic [63:0] ms, mc;
		bit neg;
		neg = (s < 0) != (c < 0);
		ms = (s < 0) ? -s : s;
		mc = (c < 0) ? -c : c;
		m = {64'd0, ms} * {64'd0, mc};
		m = (m + (128'd1 << 46)) >> 47;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// One accepted tick: advance the pose by the midpoint rule and queue it.
	function void take_tick(ddo_pkg::in_item_t it);
		longint dr, dl, s, d, cosv, sinv, nx, ny;
		logic [63:0] prod;
		logic [31:0] dth, mid, new_heading;
		bit flip;
		dr = longint'(it.right_speed) * longint'(dist_scale);
		dl = longint'(it.left_speed) * longint'(dist_scale);
		s = dr + dl;
		d = dr - dl;
		prod = d * longint'(turn_gain);
		dth = prod[55:24];
		mid = heading + prod[56:25];
		sincos_of(mid, cosv, sinv, flip);
		nx = longint'(x_pos) + step_of(s, cosv);
		ny = longint'(y_pos) + step_of(s, sinv);
		if (flip)
			n_flips++;
		if (nx != longint'(clip32(nx)) || ny != longint'(clip32(ny)))
			n_clipped++;
		x_pos = clip32(nx);
		y_pos = clip32(ny);
		new_heading = heading + dth;
		if (heading[31] == dth[31] && new_heading[31] != heading[31])
			n_wraps++;
		heading = new_heading;
		n_ticks++;
		expected_poses.push_back('{pos_x: x_pos, pos_y: y_pos, heading: heading});
	endfunction

	task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
		n_errors++;
		if (n_errors <= 50)
			$display("MISMATCH at pose %0d, %s: got %h, expected %h", n_checked, what, got_v,
				want_v);
	endtask

	// One accepted pose, compared with the oldest prediction.
	task check_result(ddo_pkg::out_item_t got);
		ddo_pkg::out_item_t want;
		if (expected_poses.size() == 0) begin
			report_mismatch("pose with no tick pending, pos_x", got.pos_x, 32'd0);
			return;
		end
		want = expected_poses.pop_front();
		n_checked++;
		if (got.pos_x !== want.pos_x)
			report_mismatch("pos_x", got.pos_x, want.pos_x);
		if (got.pos_y !== want.pos_y)
			report_mismatch("pos_y", got.pos_y, want.pos_y);
		if (got.heading !== want.heading)
			report_mismatch("heading", got.heading, want.heading);
	endtask
endclass

module tb_diff_drive_odometry;
	import ddo_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_TICKS = 125;
	localparam int CLIP_TICK_CAP = 900;
	// Heading window around 135 degrees, where forward travel heads to -x and +y.
	localparam logic [31:0] AIM_LO = 32'd1491308089;
	localparam logic [31:0] AIM_HI = 32'd1729917383;
	localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SPEED_MIN = 16'sh8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	odometry_scoreboard sb;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;
	int unsigned n_holds = 0;
	int unsigned quiet_cycles = 0;

	diff_drive_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Every pose that leaves the block is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Ends the run when neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stall bursts, and one long hold-off when asked for.
	initial begin
		int hold_cnt;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (rx_gaps ? $urandom_range(1, 8) : 1) @(posedge clk);
			end
		end
	end

	function automatic in_item_t tick_of(input logic signed [15:0] r, input logic signed [15:0] l);
		return '{right_speed: r, left_speed: l};
	endfunction

	function automatic logic signed [15:0] speed_corner();
		case ($urandom_range(0, 4))
			0: return SPEED_MAX;
			1: return SPEED_MIN;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	// Random wheel speeds: mostly any value, some slow, some nearly straight, some corners.
	function automatic in_item_t rand_tick();
		logic signed [15:0] r, l;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				r = 16'($urandom);
				l = 16'($urandom);
			end
			5, 6: begin
				r = 16'($urandom_range(0, 1023)) - 16'd512;
				l = 16'($urandom_range(0, 1023)) - 16'd512;
			end
			7: begin
				r = 16'($urandom);
				l = r + 16'($urandom_range(0, 15)) - 16'd8;
			end
			default: begin
				r = speed_corner();
				l = speed_corner();
			end
		endcase
		return tick_of(r, l);
	endfunction

	function automatic logic [CFG_W-1:0] pick_cfg(input logic [CFG_W-1:0] dflt);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return dflt;
			3: return CFG_W'($urandom_range(1, 4095));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// Offers one tick, after an optional gap, and holds it until the block takes it.
	task automatic send_tick(input in_item_t it);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.take_tick(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Waits until every pose is out and the block is idle, then sets both registers.
	task automatic configure(input logic [CFG_W-1:0] ds, input logic [CFG_W-1:0] tg);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_DISTANCE_SCALE, ds);
		write_reg(REG_TURN_GAIN, tg);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int p, n, i;
		logic signed [15:0] spin;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes to indexes without a register must leave the reset values in force.
		write_reg(REG_SPARE_2, CFG_W'($urandom));
		write_reg(REG_SPARE_3, CFG_W'($urandom));
		cfg_wen <= 1'b0;

		// Directed ticks at the reset settings: speed extremes and alternating bit patterns.
		send_tick(tick_of(16'sd0, 16'sd0));
		send_tick(tick_of(SPEED_MAX, SPEED_MAX));
		send_tick(tick_of(SPEED_MIN, SPEED_MIN));
		send_tick(tick_of(16'sh5555, 16'shAAAA));
		send_tick(tick_of(16'shAAAA, 16'sh5555));
		send_tick(tick_of(-16'sd1, 16'sd1));
		send_tick(tick_of(SPEED_MIN, SPEED_MAX));
		send_tick(tick_of(SPEED_MAX, 16'sd0));
		// Spin on the spot so that the heading passes the half turn and wraps.
		for (i = 0; i < 10; i++)
			send_tick(tick_of(SPEED_MAX, SPEED_MIN));

		// Both registers at their maximum.
		configure('1, '1);
		send_tick(tick_of(SPEED_MAX, SPEED_MIN));
		send_tick(tick_of(SPEED_MIN, SPEED_MAX));
		send_tick(tick_of(SPEED_MAX, SPEED_MAX));
		send_tick(tick_of(16'sd0, 16'sd0));

		// Turn on the spot until the heading points into the second quadrant.
		configure(DISTANCE_SCALE_RST, TURN_GAIN_RST);
		while (!(sb.heading >= AIM_LO && sb.heading <= AIM_HI)) begin
			spin = 16'($urandom_range(8000, 20000));
			send_tick(tick_of(spin, -spin));
		end

		// Drive straight at full scale until x clips low and y clips high, then hold there.
		configure('1, '0);
		n = 0;
		while (!(sb.x_pos == 32'sh80000000 && sb.y_pos == 32'sh7FFFFFFF) && n < CLIP_TICK_CAP)
				begin
			if ($urandom_range(0, 7) == 0)
				send_tick(rand_tick());
			else
				send_tick(tick_of(16'($urandom_range(30000, 32767)),
					16'($urandom_range(30000, 32767))));
			n++;
		end
		repeat (6) send_tick(tick_of(SPEED_MAX, SPEED_MAX));

		// Random phases under varied settings; one long receiver hold-off, a quiet last phase.
		for (p = 0; p < RAND_PHASES; p++) begin
			configure(p == 2 ? CFG_W'(0) : pick_cfg(DISTANCE_SCALE_RST), pick_cfg(TURN_GAIN_RST));
			if (p == RAND_PHASES - 1) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_gaps = $urandom_range(0, 3) != 0;
			end
			if (p == 1)
				hold_req = 1'b1;
			repeat (PHASE_TICKS) send_tick(rand_tick());
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d ticks and %0d register writes; %0d poses compared, %0d mismatches.",
			sb.n_ticks, sb.n_writes, sb.n_checked, sb.n_errors);
		$display("Clipped %0d times, wrapped %0d times, %0d folded angles, %0d hold-offs.",
			sb.n_clipped, sb.n_wraps, sb.n_flips, n_holds);
		if (sb.n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
